FILE: hdl/dq_pkg.sv
// Shared constants, types and command codes for the double-ended queue.
`default_nettype none
package dq_pkg;

  // Storage geometry.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Stream widths: tdata is padded to whole bytes.
  localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 8;
  localparam int OUT_TUSER_W = 8;

  // Command queue between the front and back ends.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_DUMP       = 3'd4,
    OP_SIZE       = 3'd5,
    OP_PEEK_BACK  = 3'd6,
    OP_PEEK_FRONT = 3'd7
  } opcode_t;

  // A classified command as it travels from front to back.
  typedef struct packed {
    opcode_t                op;
    logic                   is_push;
    logic                   is_read;
    logic                   is_pop;
    logic                   is_back;
    logic                   is_dump;
    logic [DATA_WIDTH-1:0]  push_value;
  } cmd_t;

  // Status that the back end reports to the top level.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             busy;
  } dq_status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOAD = 1'b1
  } back_state_t;

endpackage
`default_nettype wire

FILE: hdl/dq_front.sv
// Front end: takes input requests and classifies them into commands.
`default_nettype none
module dq_front (
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [dq_pkg::TDATA_W-1:0]   in_tdata,   // push_value
  input  wire logic [dq_pkg::IN_TUSER_W-1:0] in_tuser,  // opcode [2:0]
  output logic                              q_wr,
  output dq_pkg::cmd_t                      q_wdata,
  input  wire logic                         q_full
);
  import dq_pkg::*;

  opcode_t op;

  // A request is taken whenever the command queue has room.
  assign in_tready = !q_full;
  assign q_wr      = in_tvalid && !q_full;
  assign op        = opcode_t'(in_tuser[2:0]);

  // Classify the opcode into the flags the back end acts on.
  always_comb begin
    q_wdata            = '0;
    q_wdata.op         = op;
    q_wdata.push_value = in_tdata[DATA_WIDTH-1:0];
    unique case (op)
      OP_PUSH_BACK: begin
        q_wdata.is_push = 1'b1;
        q_wdata.is_back = 1'b1;
      end
      OP_PUSH_FRONT: begin
        q_wdata.is_push = 1'b1;
      end
      OP_POP_BACK: begin
        q_wdata.is_read = 1'b1;
        q_wdata.is_pop  = 1'b1;
        q_wdata.is_back = 1'b1;
      end
      OP_POP_FRONT: begin
        q_wdata.is_read = 1'b1;
        q_wdata.is_pop  = 1'b1;
      end
      OP_DUMP: begin
        q_wdata.is_read = 1'b1;
        q_wdata.is_back = 1'b1;
        q_wdata.is_dump = 1'b1;
      end
      OP_SIZE: begin
      end
      OP_PEEK_BACK: begin
        q_wdata.is_read = 1'b1;
        q_wdata.is_back = 1'b1;
      end
      OP_PEEK_FRONT: begin
        q_wdata.is_read = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/dq_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
`default_nettype none
module dq_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  dq_pkg::cmd_t       wr_data,
  output logic               full,
  output logic               not_empty,
  input  wire logic          rd_en,
  output dq_pkg::cmd_t       rd_data
);
  import dq_pkg::*;

  cmd_t                entries_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_AW:0]    count_r, count_nxt;
  logic                do_wr, do_rd;

  assign full      = (count_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = entries_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/dq_back.sv
// Back end: circular buffer storage, pointer update, dump sequencing and result register.
`default_nettype none
module dq_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cmd_valid,
  input  dq_pkg::cmd_t                        cmd,
  output logic                                cmd_pop,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [dq_pkg::TDATA_W-1:0]          out_tdata,  // result_value
  output logic [dq_pkg::OUT_TUSER_W-1:0]      out_tuser,  // was_empty [0], was_full [1]
  output logic                                out_tlast,  // last_of_run
  output dq_pkg::dq_status_t                  status
);
  import dq_pkg::*;

  // Position of the item at a given offset from the front.
  function automatic logic [ADDR_W-1:0] slot_at(input logic [ADDR_W-1:0] front,
                                                input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, front} + {1'b0, off};
    if (sum >= (ADDR_W+1)'(DEPTH)) begin
      sum = sum - (ADDR_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  back_state_t           state_r, state_nxt;
  logic [ADDR_W-1:0]     front_r, front_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [ADDR_W-1:0]     off_r, off_nxt;
  logic                  dump_r, dump_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                  out_empty_r, out_empty_nxt;
  logic                  out_full_r, out_full_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  out_free;
  logic                  mem_we, rd_en;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;
  logic [ADDR_W-1:0]     last_off;
  logic                  is_full;

  assign out_free = !out_valid_r || out_tready;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign last_off = ADDR_W'(count_r - CNT_W'(1));

  // Command dispatch and dump sequencing.
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    off_nxt       = off_r;
    dump_nxt      = dump_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    wr_addr       = slot_at(front_r, ADDR_W'(count_r));
    rd_addr       = slot_at(front_r, last_off);
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_empty_nxt = out_empty_r;
    out_full_nxt  = out_full_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd.is_push) begin
            if (is_full) begin
              // Dropped push: one result with the full flag.
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_empty_nxt = 1'b0;
              out_full_nxt  = 1'b1;
              out_last_nxt  = 1'b1;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + 1'b1;
              if (!cmd.is_back) begin
                front_nxt = (front_r == '0) ? ADDR_W'(DEPTH - 1) : front_r - 1'b1;
                wr_addr   = front_nxt;
              end
            end
          end else if (!cmd.is_read) begin
            // Size report.
            out_valid_nxt = 1'b1;
            out_data_nxt  = DATA_WIDTH'(count_r);
            out_empty_nxt = 1'b0;
            out_full_nxt  = 1'b0;
            out_last_nxt  = 1'b1;
          end else if (count_r == '0) begin
            // Pop, peek or dump on an empty queue.
            out_valid_nxt = 1'b1;
            out_data_nxt  = '1;
            out_empty_nxt = 1'b1;
            out_full_nxt  = 1'b0;
            out_last_nxt  = 1'b1;
          end else begin
            // Start the storage read; the data lands in the next cycle.
            rd_en     = 1'b1;
            rd_addr   = cmd.is_back ? slot_at(front_r, last_off) : front_r;
            off_nxt   = cmd.is_dump ? last_off : '0;
            dump_nxt  = cmd.is_dump;
            state_nxt = ST_LOAD;
            if (cmd.is_pop) begin
              count_nxt = count_r - 1'b1;
              if (!cmd.is_back) begin
                front_nxt = (front_r == ADDR_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;
              end
            end
          end
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_data_r;
          out_empty_nxt = 1'b0;
          out_full_nxt  = 1'b0;
          out_last_nxt  = !dump_r || (off_r == '0);
          if (dump_r && (off_r != '0)) begin
            // Next dump entry, moving toward the front.
            off_nxt = off_r - 1'b1;
            rd_en   = 1'b1;
            rd_addr = slot_at(front_r, off_nxt);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      off_r       <= '0;
      dump_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      off_r       <= off_nxt;
      dump_r      <= dump_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_empty_r <= out_empty_nxt;
    out_full_r  <= out_full_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Entry storage with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= cmd.push_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = TDATA_W'(out_data_r);
  assign out_tuser    = OUT_TUSER_W'({out_full_r, out_empty_r});
  assign out_tlast    = out_last_r;
  assign status.count = count_r;
  assign status.busy  = (state_r != ST_IDLE);

endmodule
`default_nettype wire

FILE: hdl/double_ended_queue.sv
// Top level of the double-ended queue: front end, command queue and back end.
// A dropped push, size or empty-queue result passes from the command queue to the result
// register; a pop or peek of a live item also passes through the registered storage read.
// Unless the output stalls, pushes and size reports retire one per cycle and a dump
// streams one entry per cycle; pops and peeks hold the back end in ST_LOAD for the read.
// Reset (synchronous, active low) empties the queue; stored entries are not cleared.
`default_nettype none
module double_ended_queue (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [dq_pkg::TDATA_W-1:0]      in_tdata,   // push_value
  input  wire logic [dq_pkg::IN_TUSER_W-1:0]   in_tuser,   // opcode [2:0]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [dq_pkg::TDATA_W-1:0]           out_tdata,  // result_value
  output logic [dq_pkg::OUT_TUSER_W-1:0]       out_tuser,  // was_empty [0], was_full [1]
  output logic                                 out_tlast   // last_of_run
);
  import dq_pkg::*;

  logic       q_wr, q_full, q_not_empty, q_rd;
  cmd_t       q_wdata, q_rdata;
  dq_status_t status;

  dq_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata),
    .q_full    (q_full)
  );

  dq_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (q_wr),
    .wr_data   (q_wdata),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_en     (q_rd),
    .rd_data   (q_rdata)
  );

  dq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_not_empty),
    .cmd        (q_rdata),
    .cmd_pop    (q_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .status     (status)
  );

  // The item count never exceeds the storage depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.count <= CNT_W'(DEPTH))
    else $error("item count above depth");

  // The item count moves by at most one per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (status.count == $past(status.count) ||
         status.count == $past(status.count) + 1'b1 ||
         status.count == $past(status.count) - 1'b1))
    else $error("item count jumped");

  // A result never carries both the empty and the full flag.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("empty and full flags together");

  // A flagged result is always the last one of its request.
  a_flag_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[0] || out_tuser[1])) |-> out_tlast)
    else $error("flagged result not marked last");

  // The count holds while a dump or read is being delivered.
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (status.busy && $past(status.busy)) |-> $stable(status.count))
    else $error("count changed during a read");

endmodule
`default_nettype wire
